// ===== hdl/can_frame_ring_buffer_core_macros.svh =====
// Assertion macros shared by the CAN frame ring buffer RTL.
`ifndef CAN_FRAME_RING_BUFFER_CORE_MACROS_SVH
`define CAN_FRAME_RING_BUFFER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define FRB_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ring buffer assertion failed");
// Next-cycle implication, checked outside reset.
`define FRB_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ring buffer assertion failed");
`else
`define FRB_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define FRB_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== hdl/can_frb_pkg.sv =====
// Types and constants of the CAN frame ring buffer.
package can_frb_pkg;

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int ID_W     = 29;
    localparam int FLAGS_W  = 3;
    localparam int LEN_W    = 4;
    localparam int WORD_W   = 32;
    localparam int HELD_W   = 5;
    localparam int CAP_W    = 6;
    localparam int ADDR_W   = 3;
    localparam int APB_W    = 32;

    // Operation codes of the kind field.
    localparam logic [KIND_W-1:0] KIND_RECEIVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

    // Register map: word index of each register.
    localparam logic [ADDR_W-3:0] REG_CAPACITY = 1'b0;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // One stored frame.
    typedef struct packed {
        logic [WORD_W-1:0]  stamp;
        logic [WORD_W-1:0]  data_high;
        logic [WORD_W-1:0]  data_low;
        logic [LEN_W-1:0]   length;
        logic [FLAGS_W-1:0] flags;
        logic [ID_W-1:0]    id;
    } frame_entry_t;

endpackage

// ===== hdl/can_frb_if.sv =====
// Input and result channel interfaces of the CAN frame ring buffer.
interface can_frb_in_if import can_frb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic               frame_valid;
    logic [ID_W-1:0]    frame_id;
    logic [FLAGS_W-1:0] frame_flags;
    logic [LEN_W-1:0]   frame_length;
    logic [WORD_W-1:0]  data_low;
    logic [WORD_W-1:0]  data_high;
    logic [WORD_W-1:0]  frame_time;

    modport source (
        output valid, kind, frame_valid, frame_id, frame_flags, frame_length,
               data_low, data_high, frame_time,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_valid, frame_id, frame_flags, frame_length,
               data_low, data_high, frame_time,
        output ready
    );
endinterface

interface can_frb_out_if import can_frb_pkg::*;;
    logic               valid;
    logic               ready;
    logic               out_valid;
    logic [ID_W-1:0]    out_id;
    logic [FLAGS_W-1:0] out_flags;
    logic [LEN_W-1:0]   out_length;
    logic [WORD_W-1:0]  out_data_low;
    logic [WORD_W-1:0]  out_data_high;
    logic [WORD_W-1:0]  out_time;
    logic [HELD_W-1:0]  buffered_count;
    logic [WORD_W-1:0]  received_total;
    logic [WORD_W-1:0]  dropped_total;
    logic [WORD_W-1:0]  event_total;

    modport source (
        output valid, out_valid, out_id, out_flags, out_length, out_data_low,
               out_data_high, out_time, buffered_count, received_total,
               dropped_total, event_total,
        input  ready
    );
    modport sink (
        input  valid, out_valid, out_id, out_flags, out_length, out_data_low,
               out_data_high, out_time, buffered_count, received_total,
               dropped_total, event_total,
        output ready
    );
endinterface

// ===== hdl/can_frame_ring_buffer_core.sv =====
// CAN frame ring buffer core: frame store, ring indices, counters and APB register.
// A transfer captures the frame store's registered read and the ring state; the result
// register is loaded from them once it is free to take the item.
// Throughput: one item per cycle while results are taken; the single read and write
// port of the frame store serve one item each cycle.
// Reset clears indices, counters and the result valid flag and sets capacity to 32;
// the frame store is not cleared, so the block is ready straight after reset.
`include "can_frame_ring_buffer_core_macros.svh"

module can_frame_ring_buffer_core import can_frb_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    can_frb_in_if.sink        in_ch,
    can_frb_out_if.source     out_ch
);

    // Index width and a working width that holds DEPTH, capacity and index plus one.
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW  = $clog2(DEPTH + 1) + 1;
    localparam int EW  = (DW > CAP_W + 1) ? DW : CAP_W + 1;

    // Frame store.
    frame_entry_t mem [DEPTH];
    frame_entry_t rdata_reg;

    // Control and counter state.
    logic [CAP_W-1:0]  cap_reg;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [WORD_W-1:0] acc_cnt_reg, acc_cnt_next;
    logic [WORD_W-1:0] drop_cnt_reg, drop_cnt_next;
    logic [WORD_W-1:0] event_cnt_reg, event_cnt_next;
    logic              busy_reg;
    logic              emit_reg;

    // Result register.
    logic              res_valid_reg;
    logic              res_frame_reg;
    frame_entry_t      res_entry_reg;
    logic [HELD_W-1:0] res_held_reg;
    logic [WORD_W-1:0] res_acc_reg;
    logic [WORD_W-1:0] res_drop_reg;
    logic [WORD_W-1:0] res_event_reg;

    logic              out_free;
    logic              load;
    logic              accept;
    logic              cfg_write;
    logic [EW-1:0]     cap_ext;
    logic [EW-1:0]     eff_cap;
    logic [EW-1:0]     head_inc;
    logic [EW-1:0]     tail_inc;
    logic [EW-1:0]     peek_ext;
    logic [AW-1:0]     head_adv;
    logic [AW-1:0]     tail_adv;
    logic              nonempty;
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    frame_entry_t      wr_entry;

    // APB register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ADDR_W-1:2] == REG_CAPACITY);
    assign prdata    = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? APB_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Handshake: a new item may enter when none is in flight or the pending result can move on.
    assign out_free    = !res_valid_reg || out_ch.ready;
    assign load        = busy_reg && out_free;
    assign in_ch.ready = !busy_reg || out_free;
    assign accept      = in_ch.valid && in_ch.ready;

    // Effective capacity, clamped to two and to the store depth.
    assign cap_ext = EW'(cap_reg);
    always_comb
    begin
        if (cap_ext < EW'(2))
        begin
            eff_cap = EW'(2);
        end
        else if (cap_ext > EW'(DEPTH))
        begin
            eff_cap = EW'(DEPTH);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    // Index advance with wrap at the effective capacity.
    assign head_inc = EW'(head_reg) + EW'(1);
    assign tail_inc = EW'(tail_reg) + EW'(1);
    assign head_adv = (head_inc >= eff_cap) ? '0 : head_inc[AW-1:0];
    assign tail_adv = (tail_inc >= eff_cap) ? '0 : tail_inc[AW-1:0];
    assign peek_ext = (head_reg == '0) ? (eff_cap - EW'(1)) : (EW'(head_reg) - EW'(1));
    assign nonempty = (head_reg != tail_reg);

    assign wr_entry = '{stamp:     in_ch.frame_time,
                        data_high: in_ch.data_high,
                        data_low:  in_ch.data_low,
                        length:    in_ch.frame_length,
                        flags:     in_ch.frame_flags,
                        id:        in_ch.frame_id};

    // Operation decode: next state and store accesses.
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        held_next      = held_reg;
        acc_cnt_next   = acc_cnt_reg;
        drop_cnt_next  = drop_cnt_reg;
        event_cnt_next = event_cnt_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = tail_reg;
        case (in_ch.kind)
            KIND_RECEIVE:
            begin
                event_cnt_next = event_cnt_reg + WORD_W'(1);
                if (in_ch.frame_valid)
                begin
                    if (head_adv != tail_reg)
                    begin
                        wr_en        = 1'b1;
                        head_next    = head_adv;
                        held_next    = held_reg + HELD_W'(1);
                        acc_cnt_next = acc_cnt_reg + WORD_W'(1);
                    end
                    else
                    begin
                        drop_cnt_next = drop_cnt_reg + WORD_W'(1);
                    end
                end
            end
            KIND_POP:
            begin
                if (nonempty)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = tail_reg;
                    tail_next = tail_adv;
                    held_next = held_reg - HELD_W'(1);
                end
            end
            KIND_PEEK:
            begin
                if (nonempty)
                begin
                    rd_en   = 1'b1;
                    rd_addr = peek_ext[AW-1:0];
                end
            end
            KIND_CLEAR:
            begin
                head_next = '0;
                tail_next = '0;
                held_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    // Frame store: one write port and one registered read port. A read and a write never
    // share a cycle, since each operation does one or the other, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            mem[head_reg] <= wr_entry;
        end
        if (accept && rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Ring state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            acc_cnt_reg   <= '0;
            drop_cnt_reg  <= '0;
            event_cnt_reg <= '0;
            busy_reg      <= 1'b0;
            emit_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                held_reg      <= held_next;
                acc_cnt_reg   <= acc_cnt_next;
                drop_cnt_reg  <= drop_cnt_next;
                event_cnt_reg <= event_cnt_next;
                emit_reg      <= rd_en;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (load)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload: the state registers still hold this item's values here.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_frame_reg <= emit_reg;
            res_entry_reg <= emit_reg ? rdata_reg : '0;
            res_held_reg  <= held_reg;
            res_acc_reg   <= acc_cnt_reg;
            res_drop_reg  <= drop_cnt_reg;
            res_event_reg <= event_cnt_reg;
        end
    end

    assign out_ch.valid          = res_valid_reg;
    assign out_ch.out_valid      = res_frame_reg;
    assign out_ch.out_id         = res_entry_reg.id;
    assign out_ch.out_flags      = res_entry_reg.flags;
    assign out_ch.out_length     = res_entry_reg.length;
    assign out_ch.out_data_low   = res_entry_reg.data_low;
    assign out_ch.out_data_high  = res_entry_reg.data_high;
    assign out_ch.out_time       = res_entry_reg.stamp;
    assign out_ch.buffered_count = res_held_reg;
    assign out_ch.received_total = res_acc_reg;
    assign out_ch.dropped_total  = res_drop_reg;
    assign out_ch.event_total    = res_event_reg;

    // A transfer in always leaves an item in flight.
    `FRB_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy_reg)
    // A pending item moves into a free result register and, with no new transfer, the
    // stage empties.
    `FRB_ASSERT_NXT(a_load_result, clk, rst_n, load && !accept, res_valid_reg && !busy_reg)
    // Every receive event bumps the event count by exactly one.
    `FRB_ASSERT_NXT(a_event_count, clk, rst_n, accept && (in_ch.kind == KIND_RECEIVE),
        event_cnt_reg == $past(event_cnt_reg) + WORD_W'(1))
    // A frame is only read for a pop or peek on a non-empty ring.
    `FRB_ASSERT_IMP(a_emit_kind, clk, rst_n, accept && rd_en,
        nonempty && ((in_ch.kind == KIND_POP) || (in_ch.kind == KIND_PEEK)))

endmodule

// ===== sim/can_frb_checker.sv =====
// Checker that predicts and compares every result of the CAN frame ring buffer.
`timescale 1ns / 100ps

module can_frb_checker import can_frb_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    can_frb_in_if             in_mon,
    can_frb_out_if            out_mon,
    output int                pending,
    output int                mismatches
);

    // One result as the block should report it.
    typedef struct packed {
        logic               hit;
        logic [ID_W-1:0]    id;
        logic [FLAGS_W-1:0] flags;
        logic [LEN_W-1:0]   length;
        logic [WORD_W-1:0]  data_low;
        logic [WORD_W-1:0]  data_high;
        logic [WORD_W-1:0]  stamp;
        logic [HELD_W-1:0]  held;
        logic [WORD_W-1:0]  received;
        logic [WORD_W-1:0]  dropped;
        logic [WORD_W-1:0]  events;
    } ring_response_t;

    // Shadow copy of the ring, its indices, counters and the capacity register.
    frame_entry_t      frame_mem [DEPTH];
    int unsigned       head_slot;
    int unsigned       tail_slot;
    logic [HELD_W-1:0] held_frames;
    logic [WORD_W-1:0] accepted_cnt;
    logic [WORD_W-1:0] drop_cnt;
    logic [WORD_W-1:0] event_cnt;
    logic [CAP_W-1:0]  capacity_reg;

    ring_response_t    expected_responses [$];
    ring_response_t    want;
    ring_response_t    got;
    frame_entry_t      seen_frame;

    // Ring size in use: the register value clamped to the range the store allows.
    function automatic int unsigned ring_size();
        int unsigned c;
        c = 32'(capacity_reg);
        if (c < 2)
            c = 2;
        if (c > DEPTH)
            c = DEPTH;
        return c;
    endfunction

    function automatic int unsigned next_slot(int unsigned s);
        return (s + 1 >= ring_size()) ? 0 : s + 1;
    endfunction

    // Applies one operation to the shadow ring and returns the result it causes.
    function automatic ring_response_t predict_response(logic [KIND_W-1:0] kind,
                                                        logic frame_valid,
                                                        frame_entry_t frame);
        ring_response_t r;
        int unsigned    slot;
        int unsigned    new_head;
        r    = '0;
        slot = 0;
        case (kind)
            KIND_RECEIVE:
            begin
                event_cnt++;
                if (frame_valid)
                begin
                    new_head = next_slot(head_slot);
                    if (new_head != tail_slot)
                    begin
                        frame_mem[head_slot] = frame;
                        head_slot = new_head;
                        held_frames++;
                        accepted_cnt++;
                    end
                    else
                    begin
                        drop_cnt++;
                    end
                end
            end
            KIND_POP:
            begin
                if (head_slot != tail_slot)
                begin
                    r.hit     = 1'b1;
                    slot      = tail_slot;
                    tail_slot = next_slot(tail_slot);
                    held_frames--;
                end
            end
            KIND_PEEK:
            begin
                // The newest frame sits just below the head, wrapping to the top slot.
                if (head_slot != tail_slot)
                begin
                    r.hit = 1'b1;
                    slot  = (head_slot == 0) ? ring_size() - 1 : head_slot - 1;
                end
            end
            KIND_CLEAR:
            begin
                head_slot   = 0;
                tail_slot   = 0;
                held_frames = '0;
            end
            default:
            begin
                r = '0;
            end
        endcase
        if (r.hit)
        begin
            r.id        = frame_mem[slot].id;
            r.flags     = frame_mem[slot].flags;
            r.length    = frame_mem[slot].length;
            r.data_low  = frame_mem[slot].data_low;
            r.data_high = frame_mem[slot].data_high;
            r.stamp     = frame_mem[slot].stamp;
        end
        r.held     = held_frames;
        r.received = accepted_cnt;
        r.dropped  = drop_cnt;
        r.events   = event_cnt;
        return r;
    endfunction

    task automatic check_field(string what, logic [WORD_W-1:0] expected_val,
                               logic [WORD_W-1:0] actual_val);
        if (expected_val !== actual_val)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, expected_val, actual_val);
            mismatches++;
        end
    endtask

    // Track register writes, predict on each input transfer, compare each result transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot    = 0;
            tail_slot    = 0;
            held_frames  = '0;
            accepted_cnt = '0;
            drop_cnt     = '0;
            event_cnt    = '0;
            capacity_reg = CAP_RESET;
            expected_responses.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_CAPACITY)
                capacity_reg = pwdata[CAP_W-1:0];

            if (in_mon.valid && in_mon.ready)
            begin
                seen_frame = '{stamp: in_mon.frame_time, data_high: in_mon.data_high,
                               data_low: in_mon.data_low, length: in_mon.frame_length,
                               flags: in_mon.frame_flags, id: in_mon.frame_id};
                expected_responses.push_back(
                    predict_response(in_mon.kind, in_mon.frame_valid, seen_frame));
            end

            if (out_mon.valid && out_mon.ready)
            begin
                got = '{hit: out_mon.out_valid, id: out_mon.out_id, flags: out_mon.out_flags,
                        length: out_mon.out_length, data_low: out_mon.out_data_low,
                        data_high: out_mon.out_data_high, stamp: out_mon.out_time,
                        held: out_mon.buffered_count, received: out_mon.received_total,
                        dropped: out_mon.dropped_total, events: out_mon.event_total};
                if (expected_responses.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    check_field("out_valid", WORD_W'(want.hit), WORD_W'(got.hit));
                    check_field("out_id", WORD_W'(want.id), WORD_W'(got.id));
                    check_field("out_flags", WORD_W'(want.flags), WORD_W'(got.flags));
                    check_field("out_length", WORD_W'(want.length), WORD_W'(got.length));
                    check_field("out_data_low", want.data_low, got.data_low);
                    check_field("out_data_high", want.data_high, got.data_high);
                    check_field("out_time", want.stamp, got.stamp);
                    check_field("buffered_count", WORD_W'(want.held), WORD_W'(got.held));
                    check_field("received_total", want.received, got.received);
                    check_field("dropped_total", want.dropped, got.dropped);
                    check_field("event_total", want.events, got.events);
                end
            end

            pending <= expected_responses.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Top of the CAN frame ring buffer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import can_frb_pkg::*;

    localparam int RING_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 175;
    localparam int NUM_PHASES  = 10;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic              pready;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;

    int                pending_results;
    int                mismatch_count;
    int                cycle_count;
    logic              src_steady;
    logic              sink_steady;
    int unsigned       sink_hold_cycles;
    logic [CAP_W-1:0]  phase_caps [NUM_PHASES];

    can_frb_in_if  in_if ();
    can_frb_out_if out_if ();

    can_frame_ring_buffer_core #(
        .DEPTH (RING_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_if),
        .out_ch  (out_if)
    );

    can_frb_checker #(
        .DEPTH (RING_DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_mon     (in_if),
        .out_mon    (out_if),
        .pending    (pending_results),
        .mismatches (mismatch_count)
    );

    // Free-running clock, 20 ns period.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, steady stretches, and a long hold-off on request.
    initial
    begin
        int unsigned stall_len;
        out_if.ready = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (sink_hold_cycles != 0)
            begin
                stall_len        = sink_hold_cycles;
                sink_hold_cycles = 0;
                out_if.ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
            else if (sink_steady)
            begin
                out_if.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall_len = idle_gap();
                if (stall_len != 0)
                begin
                    out_if.ready <= 1'b0;
                    repeat (stall_len) @(posedge clk);
                end
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Watchdog: a run that has not finished by the limit has failed.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offers one operation and waits for its transfer, then idles at random.
    task automatic send_op(logic [KIND_W-1:0] kind, logic frame_valid, logic [ID_W-1:0] id,
                           logic [FLAGS_W-1:0] flags, logic [LEN_W-1:0] len,
                           logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
                           logic [WORD_W-1:0] stamp);
        int unsigned gap_len;
        in_if.valid        <= 1'b1;
        in_if.kind         <= kind;
        in_if.frame_valid  <= frame_valid;
        in_if.frame_id     <= id;
        in_if.frame_flags  <= flags;
        in_if.frame_length <= len;
        in_if.data_low     <= lo;
        in_if.data_high    <= hi;
        in_if.frame_time   <= stamp;
        do
            @(posedge clk);
        while (!in_if.ready);
        gap_len = src_steady ? 0 : idle_gap();
        if (gap_len != 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap_len) @(posedge clk);
        end
    endtask

    // Pop, peek or clear; the frame fields carry random noise.
    task automatic send_cmd(logic [KIND_W-1:0] kind);
        send_op(kind, 1'($urandom_range(0, 1)), ID_W'($urandom()),
                FLAGS_W'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 8)),
                $urandom(), $urandom(), $urandom());
    endtask

    task automatic send_random_frame();
        send_op(KIND_RECEIVE, 1'b1, ID_W'($urandom()), FLAGS_W'($urandom_range(0, 7)),
                LEN_W'($urandom_range(0, 8)), $urandom(), $urandom(), $urandom());
    endtask

    // One random operation; receive_pct sets how hard the ring is pushed towards full.
    task automatic random_op(int unsigned receive_pct);
        int unsigned     pick;
        logic [ID_W-1:0] id;
        pick = $urandom_range(0, 99);
        if (pick < receive_pct)
        begin
            case ($urandom_range(0, 7))
                0:       id = '0;
                1:       id = '1;
                default: id = ID_W'($urandom());
            endcase
            send_op(KIND_RECEIVE, $urandom_range(0, 9) != 0, id,
                    FLAGS_W'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 8)),
                    $urandom(), $urandom(), $urandom());
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
                send_cmd(KIND_POP);
            else if (pick < 96)
                send_cmd(KIND_PEEK);
            else
                send_cmd(KIND_CLEAR);
        end
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic drain(int unsigned settle);
        in_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        logic [APB_W-1:0] word;
        word            = $urandom();
        word[CAP_W-1:0] = cap;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Empties the ring, sets a new capacity while idle, then runs random traffic.
    task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned items, bit with_hold);
        int unsigned receive_pct;
        send_cmd(KIND_CLEAR);
        drain(4);
        write_capacity(cap);
        receive_pct = 55;
        for (int unsigned i = 0; i < items; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       receive_pct = 85;
                    1:       receive_pct = 20;
                    default: receive_pct = 55;
                endcase
                src_steady  = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
                // Results held back for a long stretch while items keep coming.
                if (with_hold && i == 0)
                begin
                    src_steady       = 1'b1;
                    receive_pct      = 85;
                    sink_hold_cycles = 300;
                end
            end
            // Halfway through, the sender waits for every outstanding result.
            if (i == items / 2)
                drain(0);
            random_op(receive_pct);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.kind         = KIND_RECEIVE;
        in_if.frame_valid  = 1'b0;
        in_if.frame_id     = '0;
        in_if.frame_flags  = '0;
        in_if.frame_length = '0;
        in_if.data_low     = '0;
        in_if.data_high    = '0;
        in_if.frame_time   = '0;
        src_steady         = 1'b0;
        sink_steady        = 1'b0;
        sink_hold_cycles   = 0;
        phase_caps         = '{6'd32, 6'd2, 6'd0, 6'd63, 6'd1, 6'd33, 6'd17, 6'd5,
                               6'd0, 6'd31};
        phase_caps[8]      = CAP_W'($urandom_range(0, 63));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty ring straight after reset: pop and peek return no frame.
        send_cmd(KIND_POP);
        send_cmd(KIND_PEEK);
        // A receive event without data only bumps the event count.
        send_op(KIND_RECEIVE, 1'b0, '1, 3'd7, 4'd8, '1, '1, '1);
        // Frames with every field at its extremes, then a mixed pattern.
        send_op(KIND_RECEIVE, 1'b1, '1, 3'd7, 4'd8, '1, '1, '1);
        send_op(KIND_RECEIVE, 1'b1, '0, 3'd0, 4'd0, '0, '0, '0);
        send_op(KIND_RECEIVE, 1'b1, 29'h0AAA_AAAA, 3'd5, 4'd7, 32'h0123_4567,
                32'h89AB_CDEF, 32'h5555_AAAA);
        send_cmd(KIND_PEEK);
        // Three pops drain the ring and a fourth finds it empty.
        repeat (4) send_cmd(KIND_POP);
        send_random_frame();
        send_cmd(KIND_CLEAR);
        send_cmd(KIND_PEEK);

        // Smallest ring: one frame fits, the next is dropped, and peek wraps below slot zero.
        drain(4);
        write_capacity(6'd2);
        send_random_frame();
        send_random_frame();
        send_cmd(KIND_PEEK);
        send_cmd(KIND_POP);
        send_random_frame();
        send_cmd(KIND_PEEK);
        send_cmd(KIND_POP);
        send_cmd(KIND_POP);
        send_op(KIND_RECEIVE, 1'b0, '0, 3'd0, 4'd0, '0, '0, '0);

        // Random traffic over a range of capacities, out-of-range values among them.
        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(phase_caps[p], PHASE_ITEMS, p == 3);

        drain(10);
        if (mismatch_count == 0 && pending_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/can_frb_pkg.sv
hdl/can_frb_if.sv
hdl/can_frame_ring_buffer_core.sv
sim/can_frb_checker.sv
sim/tb_top.sv
